/* rtl/lsps_pkg.sv */
// Shared types, constants and lookup functions for the line sensor PD steering block.
// Holds the microcode control word, the micro-op codes and the program ROM.
// No dependencies.
package lsps_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int IDX_W        = $clog2(SENSOR_COUNT);
  localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int STEP_W       = 4;

  localparam logic REG_SPEED_LEVEL = 1'b0;

  localparam logic signed [15:0] Q8_LIMIT      = 16'sd17920;
  localparam logic signed [14:0] DIR_THRESHOLD = 15'sd768;
  localparam logic signed [16:0] KP_Q8         = 17'sd141;
  localparam logic signed [16:0] KD_Q8         = 17'sd77;
  localparam logic [7:0]         LOST_TURN_Q8  = 8'd243;
  localparam logic [7:0]         LOST_STR_Q8   = 8'd141;

  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd2;

  // multiplier operand pairs
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_DIV  = 3'd1;
  localparam logic [2:0] MUL_QCNT = 3'd2;
  localparam logic [2:0] MUL_KP   = 3'd3;
  localparam logic [2:0] MUL_KD   = 3'd4;
  localparam logic [2:0] MUL_LOST = 3'd5;

  // datapath register operations
  localparam logic [3:0] ALU_NOP   = 4'd0;
  localparam logic [3:0] ALU_INIT  = 4'd1;
  localparam logic [3:0] ALU_ACCUM = 4'd2;
  localparam logic [3:0] ALU_MAG   = 4'd3;
  localparam logic [3:0] ALU_QEST  = 4'd4;
  localparam logic [3:0] ALU_QFIX  = 4'd5;
  localparam logic [3:0] ALU_DERIV = 4'd6;
  localparam logic [3:0] ALU_PCORR = 4'd7;
  localparam logic [3:0] ALU_DCORR = 4'd8;
  localparam logic [3:0] ALU_STEER = 4'd9;
  localparam logic [3:0] ALU_LOST  = 4'd10;
  localparam logic [3:0] ALU_CLEAR = 4'd11;

  // jump conditions
  localparam logic [1:0] JMP_NEXT  = 2'd0;
  localparam logic [1:0] JMP_KIND  = 2'd1;
  localparam logic [1:0] JMP_LOOP  = 2'd2;
  localparam logic [1:0] JMP_NOHIT = 2'd3;

  // program step labels
  localparam logic [STEP_W-1:0] ST_START  = 4'd0;
  localparam logic [STEP_W-1:0] ST_ACC    = 4'd1;
  localparam logic [STEP_W-1:0] ST_MAG    = 4'd2;
  localparam logic [STEP_W-1:0] ST_DIV    = 4'd3;
  localparam logic [STEP_W-1:0] ST_QEST   = 4'd4;
  localparam logic [STEP_W-1:0] ST_QCNT   = 4'd5;
  localparam logic [STEP_W-1:0] ST_QFIX   = 4'd6;
  localparam logic [STEP_W-1:0] ST_KP     = 4'd7;
  localparam logic [STEP_W-1:0] ST_KD     = 4'd8;
  localparam logic [STEP_W-1:0] ST_DCORR  = 4'd9;
  localparam logic [STEP_W-1:0] ST_STEER  = 4'd10;
  localparam logic [STEP_W-1:0] ST_LOST   = 4'd11;
  localparam logic [STEP_W-1:0] ST_LOSTO  = 4'd12;
  localparam logic [STEP_W-1:0] ST_CLEAR  = 4'd13;

  typedef struct packed {
    logic [2:0]        mul_sel;
    logic [3:0]        alu_op;
    logic [1:0]        jmp_cond;
    logic [STEP_W-1:0] jmp_to;
    logic              last;
  } ucode_t;

  typedef struct packed {
    logic kind;
    logic loop_more;
    logic no_hit;
  } dp_status_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    unique case (step)
      ST_START: uw = '{MUL_NONE, ALU_INIT,  JMP_KIND,  ST_CLEAR, 1'b0};
      ST_ACC:   uw = '{MUL_NONE, ALU_ACCUM, JMP_LOOP,  ST_ACC,   1'b0};
      ST_MAG:   uw = '{MUL_NONE, ALU_MAG,   JMP_NOHIT, ST_LOST,  1'b0};
      ST_DIV:   uw = '{MUL_DIV,  ALU_NOP,   JMP_NEXT,  ST_START, 1'b0};
      ST_QEST:  uw = '{MUL_NONE, ALU_QEST,  JMP_NEXT,  ST_START, 1'b0};
      ST_QCNT:  uw = '{MUL_QCNT, ALU_NOP,   JMP_NEXT,  ST_START, 1'b0};
      ST_QFIX:  uw = '{MUL_NONE, ALU_QFIX,  JMP_NEXT,  ST_START, 1'b0};
      ST_KP:    uw = '{MUL_KP,   ALU_DERIV, JMP_NEXT,  ST_START, 1'b0};
      ST_KD:    uw = '{MUL_KD,   ALU_PCORR, JMP_NEXT,  ST_START, 1'b0};
      ST_DCORR: uw = '{MUL_NONE, ALU_DCORR, JMP_NEXT,  ST_START, 1'b0};
      ST_STEER: uw = '{MUL_NONE, ALU_STEER, JMP_NEXT,  ST_START, 1'b1};
      ST_LOST:  uw = '{MUL_LOST, ALU_NOP,   JMP_NEXT,  ST_START, 1'b0};
      ST_LOSTO: uw = '{MUL_NONE, ALU_LOST,  JMP_NEXT,  ST_START, 1'b1};
      ST_CLEAR: uw = '{MUL_NONE, ALU_CLEAR, JMP_NEXT,  ST_START, 1'b1};
      default:  uw = '{MUL_NONE, ALU_NOP,   JMP_NEXT,  ST_START, 1'b1};
    endcase
    return uw;
  endfunction

  function automatic logic signed [14:0] sensor_weight(input logic [IDX_W-1:0] idx);
    logic signed [14:0] w;
    unique case (idx)
      3'd0: w = -15'sd8960;
      3'd1: w = -15'sd6400;
      3'd2: w = -15'sd3840;
      3'd3: w = -15'sd1280;
      3'd4: w = 15'sd1280;
      3'd5: w = 15'sd3840;
      3'd6: w = 15'sd6400;
      3'd7: w = 15'sd8960;
      default: w = 15'sd0;
    endcase
    return w;
  endfunction

  // floor(65536 / count), with 65535 for a count of one (corrected afterward)
  function automatic logic [15:0] count_recip(input logic [CNT_W-1:0] cnt);
    logic [15:0] r;
    unique case (cnt)
      4'd1: r = 16'd65535;
      4'd2: r = 16'd32768;
      4'd3: r = 16'd21845;
      4'd4: r = 16'd16384;
      4'd5: r = 16'd13107;
      4'd6: r = 16'd10922;
      4'd7: r = 16'd9362;
      4'd8: r = 16'd8192;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [13:0] cruise_speed(input logic [1:0] level);
    logic [13:0] b;
    unique case (level)
      2'd0: b = 14'd8704;
      2'd1: b = 14'd10752;
      default: b = 14'd12800;
    endcase
    return b;
  endfunction

  function automatic logic signed [15:0] sat_target(input logic signed [16:0] v);
    logic signed [15:0] s;
    if (v > 17'(Q8_LIMIT)) begin
      s = Q8_LIMIT;
    end else if (v < -17'(Q8_LIMIT)) begin
      s = -Q8_LIMIT;
    end else begin
      s = v[15:0];
    end
    return s;
  endfunction

endpackage

/* rtl/lsps_datapath.sv */
// Datapath of the steering block: accumulator, shared multiplier, loop state, result registers.
// One control word per cycle while en is high, from the top-level sequencer; uses lsps_pkg.
module lsps_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      kind_in,
  input  logic [7:0]                bits_in,
  input  logic                      en,
  input  lsps_pkg::ucode_t          uw,
  input  logic [1:0]                speed_level,
  output lsps_pkg::dp_status_t      status,
  output logic signed [15:0]        res_left,
  output logic signed [15:0]        res_right,
  output logic signed [14:0]        res_error,
  output logic                      res_found
);

  logic                              kind_r;
  logic [7:0]                        bits_r;
  logic signed [15:0]                acc;
  logic [lsps_pkg::CNT_W-1:0]        cnt;
  logic [lsps_pkg::IDX_W-1:0]        idx;
  logic [14:0]                       mag;
  logic                              neg;
  logic [14:0]                       quot;
  logic signed [14:0]                err;
  logic signed [14:0]                prev_err;
  logic [1:0]                        turn;
  logic signed [15:0]                deriv;
  logic signed [23:0]                pacc;
  logic signed [15:0]                corr;
  logic signed [33:0]                prod;

  logic signed [16:0]                mul_a;
  logic signed [16:0]                mul_b;
  logic [13:0]                       base;
  logic [15:0]                       rem;
  logic [14:0]                       quot_fix;
  logic signed [23:0]                corr_sum;
  logic signed [15:0]                lost_val;

  assign base = lsps_pkg::cruise_speed(speed_level);

  assign status.kind      = kind_r;
  assign status.loop_more = (idx != lsps_pkg::IDX_W'(lsps_pkg::SENSOR_COUNT - 1));
  assign status.no_hit    = (cnt == '0);

  always_comb begin
    unique case (uw.mul_sel)
      lsps_pkg::MUL_DIV: begin
        mul_a = {2'b00, mag};
        mul_b = {1'b0, lsps_pkg::count_recip(cnt)};
      end
      lsps_pkg::MUL_QCNT: begin
        mul_a = {2'b00, quot};
        mul_b = {13'd0, cnt};
      end
      lsps_pkg::MUL_KP: begin
        mul_a = 17'(err);
        mul_b = lsps_pkg::KP_Q8;
      end
      lsps_pkg::MUL_KD: begin
        mul_a = 17'(deriv);
        mul_b = lsps_pkg::KD_Q8;
      end
      lsps_pkg::MUL_LOST: begin
        mul_a = {3'b000, base};
        mul_b = (turn == lsps_pkg::TURN_LEFT || turn == lsps_pkg::TURN_RIGHT) ?
                {9'd0, lsps_pkg::LOST_TURN_Q8} : {9'd0, lsps_pkg::LOST_STR_Q8};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quotient estimate is low by at most one; fix it from the remainder
  assign rem      = {1'b0, mag} - prod[15:0];
  assign quot_fix = quot + 15'((rem >= {12'd0, cnt}) ? 1 : 0);
  assign corr_sum = pacc + prod[23:0];
  assign lost_val = lsps_pkg::sat_target(prod[24:8]);

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_in;
      bits_r <= bits_in;
    end
    if (en && uw.mul_sel != lsps_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (rst) begin
      prev_err <= '0;
      turn     <= lsps_pkg::TURN_NONE;
    end else if (en) begin
      unique case (uw.alu_op)
        lsps_pkg::ALU_INIT: begin
          acc <= '0;
          cnt <= '0;
          idx <= '0;
        end
        lsps_pkg::ALU_ACCUM: begin
          if (bits_r[idx]) begin
            acc <= acc + 16'(lsps_pkg::sensor_weight(idx));
            cnt <= cnt + 1'b1;
          end
          idx <= idx + 1'b1;
        end
        lsps_pkg::ALU_MAG: begin
          neg <= acc[15];
          mag <= acc[15] ? 15'(-acc) : acc[14:0];
        end
        lsps_pkg::ALU_QEST: begin
          quot <= prod[30:16];
        end
        lsps_pkg::ALU_QFIX: begin
          err <= neg ? -$signed(quot_fix) : $signed(quot_fix);
        end
        lsps_pkg::ALU_DERIV: begin
          deriv <= 16'(err) - 16'(prev_err);
        end
        lsps_pkg::ALU_PCORR: begin
          pacc <= prod[23:0];
        end
        lsps_pkg::ALU_DCORR: begin
          corr <= corr_sum[23:8];
        end
        lsps_pkg::ALU_STEER: begin
          res_left  <= lsps_pkg::sat_target(17'(base) + 17'(corr));
          res_right <= lsps_pkg::sat_target(17'(base) - 17'(corr));
          res_error <= err;
          res_found <= 1'b1;
          prev_err  <= err;
          if (err > lsps_pkg::DIR_THRESHOLD) begin
            turn <= lsps_pkg::TURN_RIGHT;
          end else if (err < -lsps_pkg::DIR_THRESHOLD) begin
            turn <= lsps_pkg::TURN_LEFT;
          end
        end
        lsps_pkg::ALU_LOST: begin
          res_error <= prev_err;
          res_found <= 1'b0;
          if (turn == lsps_pkg::TURN_LEFT) begin
            res_left  <= '0;
            res_right <= lost_val;
          end else if (turn == lsps_pkg::TURN_RIGHT) begin
            res_left  <= lost_val;
            res_right <= '0;
          end else begin
            res_left  <= lost_val;
            res_right <= lost_val;
          end
        end
        lsps_pkg::ALU_CLEAR: begin
          prev_err  <= '0;
          turn      <= lsps_pkg::TURN_NONE;
          res_left  <= '0;
          res_right <= '0;
          res_error <= '0;
          res_found <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/line_sensor_pd_steering.sv */
// Top level of the line sensor PD steering block: request channels, APB register, sequencer.
// Depends on lsps_pkg and lsps_datapath.
//
// Usage: each input request carries kind and sensor_bits on in_valid; the block raises
// in_stall while it works on a request and takes no other. kind 0 is a sensor sample,
// kind 1 clears the loop state. Each request gives one result request on out_valid with
// wheel_left, wheel_right, line_error and line_found, held in an output register.
// A sample that sees the line runs the longest program path, a sample with no sensor
// set a shorter one and a clear the shortest. The eight-step accumulate loop over the
// sensors and the one shared multiplier (divide by reciprocal, then Kp and Kd terms)
// set these lengths; a new request is taken the cycle after the result is loaded.
// While out_stall is high the result holds; the block keeps working on the next
// request and waits at its final step until the output register is free.
// Reset (rst, synchronous) clears the previous error and turn memory, empties the
// output register and returns speed_level to 1. speed_level sits at APB byte address 0
// and the user writes it only while the block is idle; the block does not enforce this.
module line_sensor_pd_steering (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [7:0]                    sensor_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            wheel_left,
  output logic signed [15:0]            wheel_right,
  output logic signed [14:0]            line_error,
  output logic                          line_found,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsps_pkg::PADDR_W-1:0]  paddr,
  input  logic [lsps_pkg::PDATA_W-1:0]  pwdata,
  output logic [lsps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic                            busy;
  logic [lsps_pkg::STEP_W-1:0]     step;
  logic [1:0]                      speed_level;
  lsps_pkg::ucode_t                uw;
  lsps_pkg::dp_status_t            status;
  logic                            in_take;
  logic                            hold;
  logic                            en;
  logic                            taken;

  // APB register: one control word, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lsps_pkg::REG_SPEED_LEVEL) ?
                  {{(lsps_pkg::PDATA_W-2){1'b0}}, speed_level} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_level <= 2'd1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == lsps_pkg::REG_SPEED_LEVEL) begin
      speed_level <= pwdata[1:0];
    end
  end

  // Sequencer: fetch the control word for this step, advance or jump
  assign in_stall = busy;
  assign in_take  = in_valid && !busy;
  assign uw       = lsps_pkg::ucode_rom(step);
  // hold the final step while the previous result still waits downstream
  assign hold     = uw.last && out_valid && out_stall;
  assign en       = busy && !hold;

  always_comb begin
    unique case (uw.jmp_cond)
      lsps_pkg::JMP_NEXT:  taken = 1'b0;
      lsps_pkg::JMP_KIND:  taken = status.kind;
      lsps_pkg::JMP_LOOP:  taken = status.loop_more;
      lsps_pkg::JMP_NOHIT: taken = status.no_hit;
      default:             taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= lsps_pkg::ST_START;
      out_valid <= 1'b0;
    end else begin
      if (en && uw.last) begin
        // result lands in the output register this edge
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        busy <= 1'b1;
        step <= lsps_pkg::ST_START;
      end else if (en) begin
        if (uw.last) begin
          busy <= 1'b0;
        end else if (taken) begin
          step <= uw.jmp_to;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  lsps_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .load        (in_take),
    .kind_in     (kind),
    .bits_in     (sensor_bits),
    .en          (en),
    .uw          (uw),
    .speed_level (speed_level),
    .status      (status),
    .res_left    (wheel_left),
    .res_right   (wheel_right),
    .res_error   (line_error),
    .res_found   (line_found)
  );

endmodule

/* rtl/lsps_checker.sv */
// Port-level checks for the line sensor PD steering block, attached by bind.
// Depends on lsps_pkg and the line_sensor_pd_steering ports.
module lsps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [15:0]            wheel_left,
  input logic signed [15:0]            wheel_right,
  input logic signed [14:0]            line_error,
  input logic                          line_found
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(wheel_left) &&
      $stable(wheel_right) && $stable(line_error) && $stable(line_found))
    else $error("stalled result changed");

  // an accepted request keeps the input side stalled while it is worked on
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after acceptance");

  // targets stay within the saturation limits
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wheel_left <= lsps_pkg::Q8_LIMIT && wheel_left >= -lsps_pkg::Q8_LIMIT &&
      wheel_right <= lsps_pkg::Q8_LIMIT && wheel_right >= -lsps_pkg::Q8_LIMIT)
    else $error("target out of range");

  // a centroid error never exceeds the outer sensor weight
  a_error_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_error <= 15'sd8960 && line_error >= -15'sd8960)
    else $error("line error out of range");

endmodule

bind line_sensor_pd_steering lsps_checker u_lsps_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for line_sensor_pd_steering: directed table plus random sensor
// requests, with result prediction and random stalls on both request channels.
// Depends on lsps_pkg and the line_sensor_pd_steering RTL.
module tb;

  localparam int CLK_HALF      = 4;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 160;
  localparam int PHASE_ITEMS   = 75;
  localparam int REPORT_MAX    = 10;

  // loop constants, Q8
  localparam int KP_GAIN       = 141;
  localparam int KD_GAIN       = 77;
  localparam int LOST_TURN     = 243;
  localparam int LOST_STRAIGHT = 141;
  localparam int TARGET_LIMIT  = 17920;
  localparam int TURN_THRESH   = 768;
  localparam int WEIGHT_STEP   = 1280;

  localparam logic [lsps_pkg::PADDR_W-1:0] ADDR_SPEED_LEVEL =
    {lsps_pkg::REG_SPEED_LEVEL, 2'b00};

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [14:0] err;
    logic               found;
  } steer_t;

  typedef struct packed {
    logic   kind;
    logic [7:0] bits;
    logic   typed;
    steer_t want;
  } stim_row_t;

  localparam int DIR_ROWS = 25;

  // Rows with typed = 1 carry the expected result worked out by hand (speed level 1).
  localparam stim_row_t DIRECTED[DIR_ROWS] = '{
    // lost line straight after reset: both wheels at 141/256 of base
    '{1'b0, 8'h00, 1'b1, '{16'sd5922, 16'sd5922, 15'sd0, 1'b0}},
    // clear with every sensor bit set: bits are ignored
    '{1'b1, 8'hFF, 1'b1, '{16'sd0, 16'sd0, 15'sd0, 1'b0}},
    // leftmost sensor: full negative error, right target saturates
    '{1'b0, 8'h01, 1'b1, '{16'sd3122, 16'sd17920, -15'sd8960, 1'b1}},
    // line lost after a left turn
    '{1'b0, 8'h00, 1'b1, '{16'sd0, 16'sd10206, -15'sd8960, 1'b0}},
    '{1'b1, 8'h00, 1'b1, '{16'sd0, 16'sd0, 15'sd0, 1'b0}},
    // rightmost sensor: full positive error, left target saturates
    '{1'b0, 8'h80, 1'b1, '{16'sd17920, 16'sd3122, 15'sd8960, 1'b1}},
    // line lost after a right turn
    '{1'b0, 8'h00, 1'b1, '{16'sd10206, 16'sd0, 15'sd8960, 1'b0}},
    // all sensors: zero error, pure derivative kick
    '{1'b0, 8'hFF, 1'b1, '{16'sd8057, 16'sd13447, 15'sd0, 1'b1}},
    // small error keeps the right-turn memory
    '{1'b0, 8'h00, 1'b1, '{16'sd10206, 16'sd0, 15'sd0, 1'b0}},
    '{1'b1, 8'h5A, 1'b1, '{16'sd0, 16'sd0, 15'sd0, 1'b0}},
    '{1'b0, 8'h00, 1'b1, '{16'sd5922, 16'sd5922, 15'sd0, 1'b0}},
    // the rest go through the predictor: centered, edges, odd counts, symmetric
    '{1'b0, 8'h18, 1'b0, '0},
    '{1'b0, 8'h03, 1'b0, '0},
    '{1'b0, 8'hC0, 1'b0, '0},
    '{1'b0, 8'hAA, 1'b0, '0},
    '{1'b0, 8'h55, 1'b0, '0},
    '{1'b0, 8'h81, 1'b0, '0},
    '{1'b0, 8'h07, 1'b0, '0},
    '{1'b0, 8'h1C, 1'b0, '0},
    '{1'b0, 8'h0B, 1'b0, '0},
    '{1'b0, 8'hD0, 1'b0, '0},
    '{1'b0, 8'h38, 1'b0, '0},
    '{1'b0, 8'hFE, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'h10, 1'b0, '0}
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                kind;
  logic [7:0]          sensor_bits;
  logic                out_valid;
  logic                out_stall;
  logic signed [15:0]  wheel_left;
  logic signed [15:0]  wheel_right;
  logic signed [14:0]  line_error;
  logic                line_found;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [lsps_pkg::PADDR_W-1:0]  paddr;
  logic [lsps_pkg::PDATA_W-1:0]  pwdata;
  logic [lsps_pkg::PDATA_W-1:0]  prdata;
  logic                pready;

  line_sensor_pd_steering dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .sensor_bits  (sensor_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .wheel_left   (wheel_left),
    .wheel_right  (wheel_right),
    .line_error   (line_error),
    .line_found   (line_found),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow copy of the loop state and the speed register.
  logic [1:0]         speed_shadow;
  logic signed [14:0] last_error;
  logic [1:0]         turn_shadow;

  steer_t pending_steer[$];
  int     mismatches = 0;
  int     sent_count;
  logic   calm;        // no idling on either side while set
  int     quiet_cycles = 0;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic int clamp_target(input int v);
    if (v > TARGET_LIMIT) return TARGET_LIMIT;
    if (v < -TARGET_LIMIT) return -TARGET_LIMIT;
    return v;
  endfunction

  // Work out the result of one accepted request and advance the shadow state.
  function automatic steer_t predict_steering(input logic k, input logic [7:0] bits);
    steer_t r;
    int     base;
    int     sum;
    int     cnt;
    int     err;
    int     corr;
    r = '0;
    case (speed_shadow)
      2'd0:    base = 8704;
      2'd1:    base = 10752;
      default: base = 12800;   // unused level 3 runs at the top speed
    endcase
    if (k) begin
      last_error  = '0;
      turn_shadow = lsps_pkg::TURN_NONE;
      return r;
    end
    sum = 0;
    cnt = 0;
    for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin
      if (bits[i]) begin
        sum += (2 * i - 7) * WEIGHT_STEP;
        cnt++;
      end
    end
    if (cnt > 0) begin
      err  = sum / cnt;                       // truncates toward zero
      corr = (err * KP_GAIN + (err - int'(last_error)) * KD_GAIN) >>> 8;
      last_error = 15'(err);
      if (err > TURN_THRESH) begin
        turn_shadow = lsps_pkg::TURN_RIGHT;
      end else if (err < -TURN_THRESH) begin
        turn_shadow = lsps_pkg::TURN_LEFT;
      end
      r.left  = 16'(clamp_target(base + corr));
      r.right = 16'(clamp_target(base - corr));
      r.err   = 15'(err);
      r.found = 1'b1;
    end else begin
      r.err = last_error;
      case (turn_shadow)
        lsps_pkg::TURN_LEFT: begin
          r.right = 16'(clamp_target((base * LOST_TURN) >>> 8));
        end
        lsps_pkg::TURN_RIGHT: begin
          r.left = 16'(clamp_target((base * LOST_TURN) >>> 8));
        end
        default: begin
          r.left  = 16'(clamp_target((base * LOST_STRAIGHT) >>> 8));
          r.right = r.left;
        end
      endcase
    end
    return r;
  endfunction

  // Random sensor pattern: mostly a narrow line under the bar, some lost-line
  // samples, the rest noise.
  function automatic logic [7:0] pick_sensor_bits();
    int roll;
    int width;
    int pos;
    roll = $urandom_range(99);
    if (roll < 12) return 8'h00;
    if (roll < 62) begin
      width = $urandom_range(3, 1);
      pos   = $urandom_range(8 - width, 0);
      return 8'(((1 << width) - 1) << pos);
    end
    return 8'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    if (mismatches < REPORT_MAX) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
    mismatches++;
  endtask

  // Offer one request and hold it until the block takes it. Called right after a
  // rising edge; returns right after the accepting edge.
  task automatic send_request(input logic k, input logic [7:0] bits,
                              input logic typed, input steer_t want);
    steer_t predicted;
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    sensor_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_steering(k, bits);
    pending_steer.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every expected result has come back.
  task automatic wait_drained();
    while (pending_steer.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge where psel, penable, pwrite and pready are all high.
  task automatic write_speed_level(input logic [1:0] level);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SPEED_LEVEL;
    pwdata  <= lsps_pkg::PDATA_W'(level);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    speed_shadow = level;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block go idle, then change the speed level.
  task automatic change_speed(input logic [1:0] level);
    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_speed_level(level);
  endtask

  // Result side: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    steer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_steer.size() == 0) begin
        report_mismatch("unexpected result, wheel_left", 0, wheel_left);
      end else begin
        want = pending_steer.pop_front();
        if (wheel_left !== want.left) begin
          report_mismatch("wheel_left", $signed(want.left), wheel_left);
        end
        if (wheel_right !== want.right) begin
          report_mismatch("wheel_right", $signed(want.right), wheel_right);
        end
        if (line_error !== want.err) begin
          report_mismatch("line_error", $signed(want.err), line_error);
        end
        if (line_found !== want.found) begin
          report_mismatch("line_found", want.found, line_found);
        end
      end
    end
  end

  // Receiver stalls: random in normal running, none while calm, and one long
  // hold-off once enough requests went in so the block backs up into in_stall.
  int   hold_left;
  logic hold_done;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= 120) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("line_sensor_pd_steering test failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] phase_levels[5];
    logic       k;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = 1'b0;
    sensor_bits  = 8'h00;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    speed_shadow = 2'd1;
    last_error   = '0;
    turn_shadow  = lsps_pkg::TURN_NONE;
    sent_count   = 0;
    calm         = 1'b0;
    phase_levels = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset speed level.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(DIRECTED[i].kind, DIRECTED[i].bits, DIRECTED[i].typed,
                   DIRECTED[i].want);
    end

    // Random phases, one speed level each; the third phase runs without idling.
    for (int p = 0; p < 5; p++) begin
      change_speed(phase_levels[p]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // once, let the sender pause until everything has come back
        if (p == 3 && n == 30) begin
          drop_valid();
          wait_drained();
        end
        k = ($urandom_range(99) < 6);
        send_request(k, k ? 8'($urandom()) : pick_sensor_bits(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("line_sensor_pd_steering test passed");
    end else begin
      $display("line_sensor_pd_steering test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lsps_pkg.sv
rtl/lsps_datapath.sv
rtl/line_sensor_pd_steering.sv
rtl/lsps_checker.sv
dv/tb.sv
